// ----- design/hsvc_pkg.sv -----
// shared types and constants for the rgb to hsv window classifier
// no dependencies

package hsvc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned RegW    = 9;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned HueNumW = 14;
  localparam int unsigned HueDivW = 13;
  localparam int unsigned HueQW   = 6;
  localparam int unsigned SatNumW = 16;
  localparam int unsigned SatQW   = 9;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  localparam logic [RegIdxW-1:0] REG_HUE_LOW  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HUE_HIGH = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SAT_LOW  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_SAT_HIGH = 3'd3;
  localparam logic [RegIdxW-1:0] REG_VAL_LOW  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_VAL_HIGH = 3'd5;

  localparam logic [ChanW-1:0] HUE_BASE_RED   = 8'd0;
  localparam logic [ChanW-1:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [ChanW-1:0] HUE_BASE_BLUE  = 8'd170;

  localparam logic [RegW-1:0] RST_HUE_LOW  = 9'd0;
  localparam logic [RegW-1:0] RST_HUE_HIGH = 9'd256;
  localparam logic [RegW-1:0] RST_SAT_LOW  = 9'd0;
  localparam logic [RegW-1:0] RST_SAT_HIGH = 9'd257;
  localparam logic [RegW-1:0] RST_VAL_LOW  = 9'd0;
  localparam logic [RegW-1:0] RST_VAL_HIGH = 9'd256;

  typedef struct packed {
    logic [RegW-1:0] hue_low;
    logic [RegW-1:0] hue_high;
    logic [RegW-1:0] sat_low;
    logic [RegW-1:0] sat_high;
    logic [RegW-1:0] val_low;
    logic [RegW-1:0] val_high;
  } win_cfg_t;

  // after max/min and sector selection
  typedef struct packed {
    logic [ChanW-1:0] val;
    logic [ChanW-1:0] chroma;
    logic [ChanW-1:0] base;
    logic             neg;
    logic             grey;
    logic [ChanW-1:0] dmag;
  } front_t;

  // division in flight
  typedef struct packed {
    logic [ChanW-1:0]   val;
    logic [ChanW-1:0]   chroma;
    logic [ChanW-1:0]   base;
    logic               neg;
    logic               grey;
    logic [HueNumW-1:0] hrem;
    logic [HueDivW-1:0] hdsh;
    logic [HueQW-1:0]   hq;
    logic [SatNumW-1:0] srem;
    logic [SatNumW-1:0] sdsh;
    logic [SatQW-1:0]   sq;
  } div_t;

  typedef struct packed {
    logic             mask;
    logic [ChanW-1:0] hue;
    logic [RegW-1:0]  sat;
    logic [ChanW-1:0] val;
    logic [ChanW-1:0] chroma;
  } result_t;

endpackage

// ----- design/hsvc_front.sv -----
// front end: max/min, chroma, sector choice, then numerators and shifted divisors
// depends on hsvc_pkg

module hsvc_front import hsvc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             valid_o,
  input  logic             ready_i,
  output div_t             data_o
);

  logic       s1_valid_q;
  logic       s1_ready;
  front_t     s1_d, s1_q;
  logic       s2_valid_q;
  div_t       s2_d, s2_q;
  logic [ChanW-1:0] mx, mn, pa, pb;
  logic [ChanW:0]   diff;
  logic [HueNumW-1:0] dm;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    if (red_i > green_i && red_i > blue_i) begin
      pa = green_i;
      pb = blue_i;
      s1_d.base = HUE_BASE_RED;
    end else if (green_i > blue_i) begin
      pa = blue_i;
      pb = red_i;
      s1_d.base = HUE_BASE_GREEN;
    end else begin
      pa = red_i;
      pb = green_i;
      s1_d.base = HUE_BASE_BLUE;
    end
    diff        = {1'b0, pa} - {1'b0, pb};
    s1_d.neg    = diff[ChanW];
    s1_d.dmag   = diff[ChanW] ? (pb - pa) : (pa - pb);
    s1_d.val    = mx;
    s1_d.chroma = mx - mn;
    s1_d.grey   = (mx == mn);
  end

  assign s1_ready = !s2_valid_q || ready_i;
  assign ready_o  = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready_o) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s1_q <= s1_d;
    end
  end

  // times 43 as shifts and adds
  always_comb begin
    dm = {{(HueNumW-ChanW){1'b0}}, s1_q.dmag};
    s2_d.val    = s1_q.val;
    s2_d.chroma = s1_q.chroma;
    s2_d.base   = s1_q.base;
    s2_d.neg    = s1_q.neg;
    s2_d.grey   = s1_q.grey;
    s2_d.hrem   = (dm << 5) + (dm << 3) + (dm << 1) + dm;
    s2_d.hdsh   = {s1_q.chroma, 5'b0};
    s2_d.hq     = '0;
    s2_d.srem   = {s1_q.chroma, 8'b0};
    s2_d.sdsh   = {s1_q.val, 8'b0};
    s2_d.sq     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ready) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

// ----- design/hsvc_div_stage.sv -----
// one stage of the two restoring dividers: three saturation bits, two hue bits
// depends on hsvc_pkg

module hsvc_div_stage import hsvc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  div_t nx, data_q;
  logic valid_q;

  always_comb begin
    nx = data_i;
    for (int k = 0; k < 3; k++) begin
      if (nx.srem >= nx.sdsh) begin
        nx.srem = nx.srem - nx.sdsh;
        nx.sq   = {nx.sq[SatQW-2:0], 1'b1};
      end else begin
        nx.sq   = {nx.sq[SatQW-2:0], 1'b0};
      end
      nx.sdsh = nx.sdsh >> 1;
    end
    for (int k = 0; k < 2; k++) begin
      if (nx.hrem >= {1'b0, nx.hdsh}) begin
        nx.hrem = nx.hrem - {1'b0, nx.hdsh};
        nx.hq   = {nx.hq[HueQW-2:0], 1'b1};
      end else begin
        nx.hq   = {nx.hq[HueQW-2:0], 1'b0};
      end
      nx.hdsh = nx.hdsh >> 1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= nx;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/hsvc_back.sv -----
// back end: hue assembly, window tests and output register
// depends on hsvc_pkg

module hsvc_back import hsvc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  win_cfg_t cfg_i,
  input  logic     valid_i,
  output logic     ready_o,
  input  div_t     data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output result_t  data_o
);

  result_t res_d, res_q;
  logic    valid_q;
  logic [ChanW-1:0] q8;
  logic    hue_ok, sat_ok, val_ok;

  always_comb begin
    q8 = {{(ChanW-HueQW){1'b0}}, data_i.hq};
    res_d.hue    = data_i.grey ? '0 : (data_i.neg ? data_i.base - q8 : data_i.base + q8);
    res_d.sat    = data_i.grey ? '0 : data_i.sq;
    res_d.val    = data_i.val;
    res_d.chroma = data_i.chroma;
    hue_ok = ({1'b0, res_d.hue} > cfg_i.hue_low) && ({1'b0, res_d.hue} < cfg_i.hue_high);
    sat_ok = (res_d.sat > cfg_i.sat_low) && (res_d.sat < cfg_i.sat_high);
    val_ok = ({1'b0, res_d.val} > cfg_i.val_low) && ({1'b0, res_d.val} < cfg_i.val_high);
    res_d.mask = hue_ok && sat_ok && val_ok;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;

endmodule

// ----- design/rgb_hsv_window_classifier_core.sv -----
// rgb to hsv conversion with hue/saturation/value window test, one pixel per cycle while the output is not stalled
// throughput one word per cycle while the output is not stalled
// six register stages: front (two), divider stages (three), output (one)
// each stage holds its word while the next is stalled; bubbles close up
// reset clears all valid bits and loads the window registers with their RST_* defaults
// depends on hsvc_pkg, hsvc_front, hsvc_div_stage, hsvc_back

module rgb_hsv_window_classifier_core import hsvc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [RegW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // red, green, blue
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // mask, hue, saturation, brightness, chroma, zeros
);

  win_cfg_t cfg_q;
  logic     fr_valid, fr_ready;
  div_t     fr_data;
  logic     d0_valid, d0_ready, d1_valid, d1_ready, d2_valid, d2_ready;
  div_t     d0_data, d1_data, d2_data;
  logic     bk_valid;
  result_t  bk_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= RST_HUE_LOW;
      cfg_q.hue_high <= RST_HUE_HIGH;
      cfg_q.sat_low  <= RST_SAT_LOW;
      cfg_q.sat_high <= RST_SAT_HIGH;
      cfg_q.val_low  <= RST_VAL_LOW;
      cfg_q.val_high <= RST_VAL_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HUE_LOW:  cfg_q.hue_low  <= cfg_data_i;
        REG_HUE_HIGH: cfg_q.hue_high <= cfg_data_i;
        REG_SAT_LOW:  cfg_q.sat_low  <= cfg_data_i;
        REG_SAT_HIGH: cfg_q.sat_high <= cfg_data_i;
        REG_VAL_LOW:  cfg_q.val_low  <= cfg_data_i;
        REG_VAL_HIGH: cfg_q.val_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hsvc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  hsvc_div_stage u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_data),
    .valid_o (d0_valid),
    .ready_i (d0_ready),
    .data_o  (d0_data)
  );

  hsvc_div_stage u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d0_valid),
    .ready_o (d0_ready),
    .data_i  (d0_data),
    .valid_o (d1_valid),
    .ready_i (d1_ready),
    .data_o  (d1_data)
  );

  hsvc_div_stage u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d1_valid),
    .ready_o (d1_ready),
    .data_i  (d1_data),
    .valid_o (d2_valid),
    .ready_i (d2_ready),
    .data_o  (d2_data)
  );

  hsvc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (d2_valid),
    .ready_o (d2_ready),
    .data_i  (d2_data),
    .valid_o (bk_valid),
    .ready_i (m_axis_tready),
    .data_o  (bk_data)
  );

  assign m_axis_tvalid = bk_valid;
  assign m_axis_tdata  = {6'b0, bk_data.chroma, bk_data.val, bk_data.sat,
                          bk_data.hue, bk_data.mask};

endmodule

// ----- test/tb.sv -----
// testbench for rgb_hsv_window_classifier_core: random and corner pixels, window settings
// predicts hue, saturation, value, chroma and mask per pixel and checks every result word
// depends on hsvc_pkg and the core

module tb;
  import hsvc_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseWords = 150;
  localparam int unsigned PhaseCount = 13;
  localparam int unsigned HoldAfter  = 560;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned FieldsW    = 34;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned IdleMax    = 17;
  localparam int unsigned RegMax     = 511;

  // indexes past the last window register, writes there must be ignored
  localparam logic [RegIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_e;

  class hsv_board;
    win_cfg_t    win;
    result_t     expected_hsv[$];
    int unsigned errors;

    function new();
      win.hue_low  = RST_HUE_LOW;
      win.hue_high = RST_HUE_HIGH;
      win.sat_low  = RST_SAT_LOW;
      win.sat_high = RST_SAT_HIGH;
      win.val_low  = RST_VAL_LOW;
      win.val_high = RST_VAL_HIGH;
      errors = 0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [RegW-1:0] data);
      case (idx)
        REG_HUE_LOW:  win.hue_low  = data;
        REG_HUE_HIGH: win.hue_high = data;
        REG_SAT_LOW:  win.sat_low  = data;
        REG_SAT_HIGH: win.sat_high = data;
        REG_VAL_LOW:  win.val_low  = data;
        REG_VAL_HIGH: win.val_high = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_hsv.size();
    endfunction

    function void predict_hsv(logic [InDataW-1:0] px);
      int r, g, b, mx, mn, c, h, s;
      result_t want;
      r = int'(px[7:0]);
      g = int'(px[15:8]);
      b = int'(px[23:16]);
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      if (c == 0) begin
        h = 0;
      end else if (r > g && r > b) begin
        h = (43 * (g - b)) / c;
      end else if (g > b) begin
        h = 85 + (43 * (b - r)) / c;
      end else begin
        h = 170 + (43 * (r - g)) / c;
      end
      if (h < 0) h += 256;
      s = (mx != 0) ? (256 * c) / mx : 0;
      want.mask = h > int'(win.hue_low) && h < int'(win.hue_high) &&
                  s > int'(win.sat_low) && s < int'(win.sat_high) &&
                  mx > int'(win.val_low) && mx < int'(win.val_high);
      want.hue    = h[7:0];
      want.sat    = s[8:0];
      want.val    = mx[7:0];
      want.chroma = c[7:0];
      expected_hsv = {expected_hsv, want};
    endfunction

    function void check_word(logic [OutDataW-1:0] w);
      result_t got, want;
      got.mask   = w[0];
      got.hue    = w[8:1];
      got.sat    = w[17:9];
      got.val    = w[25:18];
      got.chroma = w[33:26];
      if (expected_hsv.size() == 0) begin
        errors++;
        if (errors <= ReportMax) $display("unexpected result word %h", w);
        return;
      end
      want = expected_hsv.pop_front();
      if (got.mask !== want.mask || got.hue !== want.hue || got.sat !== want.sat ||
          got.val !== want.val || got.chroma !== want.chroma ||
          w[OutDataW-1:FieldsW] !== '0) begin
        errors++;
        if (errors <= ReportMax) begin
          $display("mismatch: expected mask %0d hue %0d sat %0d val %0d chroma %0d",
                   want.mask, want.hue, want.sat, want.val, want.chroma);
          $display("          got      mask %0d hue %0d sat %0d val %0d chroma %0d pad %h",
                   got.mask, got.hue, got.sat, got.val, got.chroma,
                   w[OutDataW-1:FieldsW]);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i = '0;
  logic [RegW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // red, green, blue
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // mask, hue, saturation, brightness, chroma, zeros

  idle_mode_e idle_mode = IDLE_NONE;
  hsv_board   sb = new();

  // corner pixels, written as blue, green, red
  logic [InDataW-1:0] corner_px[$] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00, 24'hFF0000,
    24'h0A00FF, 24'h00C8C8, 24'hC800C8, 24'hC8C800, 24'h000001, 24'h010000,
    24'h00FEFF, 24'h010001, 24'h7F80FF, 24'hFF7F00, 24'h010101, 24'hFEFEFF,
    24'h00FF01, 24'hFF00FE, 24'h000100
  };

  rgb_hsv_window_classifier_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.predict_hsv(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end
  end

  function automatic int unsigned idle_draw();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, IdleMax);
      default:   return ($urandom_range(0, 5) == 0) ? $urandom_range(0, IdleMax) : 0;
    endcase
  endfunction

  function automatic logic [InDataW-1:0] rand_pixel();
    logic [ChanW-1:0] r, g, b, v;
    r = ChanW'($urandom_range(0, 255));
    g = ChanW'($urandom_range(0, 255));
    b = ChanW'($urandom_range(0, 255));
    v = ChanW'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: begin
        r = v;
        g = v;
        b = v;
      end
      1: begin
        r = v;
        g = v;
      end
      2: begin
        g = v;
        b = v;
      end
      3: begin
        r = v;
        b = v;
      end
      4: begin
        r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return {b, g, r};
  endfunction

  task automatic send_pixel(input logic [InDataW-1:0] px);
    int unsigned gap;
    gap = idle_draw();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_windows(input int unsigned hl, input int unsigned hh,
                             input int unsigned sl, input int unsigned sh,
                             input int unsigned vl, input int unsigned vh);
    write_reg(REG_HUE_LOW,  RegW'(hl));
    write_reg(REG_HUE_HIGH, RegW'(hh));
    write_reg(REG_SAT_LOW,  RegW'(sl));
    write_reg(REG_SAT_HIGH, RegW'(sh));
    write_reg(REG_VAL_LOW,  RegW'(vl));
    write_reg(REG_VAL_HIGH, RegW'(vh));
    write_reg(REG_SPARE_A,  RegW'($urandom_range(0, RegMax)));
    write_reg(REG_SPARE_B,  RegW'($urandom_range(0, RegMax)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int unsigned upper_of(int unsigned lo);
    int unsigned hi;
    hi = lo + $urandom_range(2, 300);
    return (hi > RegMax) ? RegMax : hi;
  endfunction

  task automatic pick_windows(input int unsigned phase);
    int unsigned hl, sl, vl;
    case (phase)
      0: set_windows(0, 256, 0, 257, 0, 256);
      1: set_windows(0, RegMax, 0, RegMax, 0, RegMax);
      2: set_windows(100, 101, 0, RegMax, 0, RegMax);
      3: set_windows(RegMax, 0, RegMax, 0, RegMax, 0);
      4: set_windows(20, 120, 60, 200, 40, 220);
      5: set_windows(0, 256, 255, 257, 0, 256);
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          set_windows($urandom_range(0, RegMax), $urandom_range(0, RegMax),
                      $urandom_range(0, RegMax), $urandom_range(0, RegMax),
                      $urandom_range(0, RegMax), $urandom_range(0, RegMax));
        end else begin
          hl = $urandom_range(0, 160);
          sl = $urandom_range(0, 160);
          vl = $urandom_range(0, 160);
          set_windows(hl, upper_of(hl), sl, upper_of(sl), vl, upper_of(vl));
        end
      end
    endcase
  endtask

  // receiver with per word stalls and one long hold-off
  initial begin
    int unsigned stall, taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_draw();
      if (taken == HoldAfter) stall = HoldCycles;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[rgb_hsv_window_classifier_core] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner pixels under the reset windows
    idle_mode = IDLE_SPARSE;
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      pick_windows(p);
      idle_mode = idle_mode_e'(p % 3);
      for (int unsigned n = 0; n < PhaseWords; n++) send_pixel(rand_pixel());
      s_axis_tvalid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[rgb_hsv_window_classifier_core] OK");
    end else begin
      $display("[rgb_hsv_window_classifier_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- rgb_hsv_window_classifier_core.f -----
design/hsvc_pkg.sv
design/hsvc_front.sv
design/hsvc_div_stage.sv
design/hsvc_back.sv
design/rgb_hsv_window_classifier_core.sv
test/tb.sv
